@@ rtl/core/spb_pkg.sv @@
// Shared types and constants for the spectrum bin smoother.
// Holds the sequencer state type, smoothing mode codes and register indexes.
// No dependencies.
package spb_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned MagW     = 16;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned WinLenW  = 5;
  localparam int unsigned RecipW   = 17;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  // Peak never reported below -300 dB (units of 1/64 dB)
  localparam logic signed [MagW-1:0] PeakFloor = -16'sd19200;

  // Smoothing mode codes
  localparam logic [ModeW-1:0] ModeNone = 2'd0;
  localparam logic [ModeW-1:0] ModeAvg  = 2'd1;
  localparam logic [ModeW-1:0] ModePeak = 2'd2;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] RegMode   = 2'd0;
  localparam logic [1:0] RegWinLen = 2'd1;
  localparam logic [1:0] RegRecip  = 2'd2;

  // Reset values of the registers
  localparam logic [ModeW-1:0]   ModeReset   = ModeNone;
  localparam logic [WinLenW-1:0] WinLenReset = 5'd1;
  localparam logic [RecipW-1:0]  RecipReset  = 17'd65536;

  // Per-word sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_OUT
  } seq_state_e;

endpackage

@@ rtl/core/spectrum_bin_smoother.sv @@
// Spectrum bin smoother: none / moving average / windowed peak over a bin stream.
// Single module with the window memory inside; depends on spb_pkg.
//
// Usage:
//   s_axis: one word per bin, tdata = magnitude, tuser = first-bin flag.
//   m_axis: zero or one word per bin, tdata = {smoothed_value, bin_index}.
//   APB: smoothing_mode at 0x0, window_length at 0x4, avg_reciprocal at 0x8;
//   write only while the block is idle.
// Timing:
//   A word taken in the idle state passes through a scan, a multiply and an
//   output state. The scan is set by the window memory read port: the older
//   count - 1 bins, count = min(bin index + 1, N), are read one per cycle to
//   form sum and peak.
//   The result sits in an output register, so a new word is taken while a
//   result still waits; the output cycle holds until that register is free.
// Reset:
//   Counter, write pointer, registers and valids clear; the window memory is
//   not cleared, as only bins written in the current channel are read.
// Stall:
//   A stalled receiver holds m_axis_tvalid and data; at most one more word
//   with a result is taken before the input side stops (dropped words pass).
module spectrum_bin_smoother #(
  parameter int unsigned WINDOW_MAX = 16,
  parameter int unsigned BIN_MAX    = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // tdata: [15:0] magnitude
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [spb_pkg::MagW-1:0]              s_axis_tdata,
  // tuser: [0] first_bin
  input  logic                                  s_axis_tuser,
  // tdata: [BinW-1:0] bin_index, [BinW+15:BinW] smoothed_value, zero fill
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((($clog2(BIN_MAX) + 16) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // APB configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [spb_pkg::ApbAddrW-1:0]          paddr,
  input  logic [spb_pkg::ApbDataW-1:0]          pwdata,
  output logic [spb_pkg::ApbDataW-1:0]          prdata,
  output logic                                  pready
);

  localparam int unsigned BinW   = $clog2(BIN_MAX);
  localparam int unsigned OutW   = ((BinW + 16 + 7) / 8) * 8;
  localparam int unsigned PtrW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned NW     = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SumW   = spb_pkg::MagW + $clog2(WINDOW_MAX);
  localparam int unsigned ProdW  = SumW + spb_pkg::RecipW + 1;
  localparam logic [BinW-1:0] BinLast = BinW'(BIN_MAX - 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(WINDOW_MAX - 1);
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(32768);
  localparam logic signed [ProdW-1:0] SatHi     = ProdW'(32767);
  localparam logic signed [ProdW-1:0] SatLo     = ProdW'(-32768);

  // Configuration registers
  logic [spb_pkg::ModeW-1:0]   mode_q;
  logic [spb_pkg::WinLenW-1:0] win_len_q;
  logic [spb_pkg::RecipW-1:0]  recip_q;

  // Control state
  spb_pkg::seq_state_e state_q, state_d;
  logic [BinW-1:0] cnt_q;
  logic [PtrW-1:0] wp_q;
  logic [PtrW-1:0] rptr_q;
  logic [NW-1:0]   left_q;
  logic            pend_q;
  logic            out_valid_q;

  // Per-word payload
  logic signed [spb_pkg::MagW-1:0] mag_q;
  logic [BinW-1:0]                 idx_q;
  logic signed [SumW-1:0]          sum_q;
  logic signed [spb_pkg::MagW-1:0] peak_q;
  logic signed [ProdW-1:0]         prod_q;
  logic [OutW-1:0]                 out_data_q;

  // Window memory
  logic signed [spb_pkg::MagW-1:0] win_mem [WINDOW_MAX];
  logic signed [spb_pkg::MagW-1:0] rd_data_q;

  logic                            accept;
  logic                            rd_issue;
  logic                            out_load;
  logic                            out_free;
  logic                            drop;
  logic                            cfg_wr;
  logic [NW-1:0]                   n_eff;
  logic [BinW-1:0]                 idx_in;
  logic [PtrW-1:0]                 wp_base;
  logic signed [spb_pkg::MagW-1:0] mag_in;
  logic signed [ProdW-1:0]         rounded;
  logic signed [ProdW-1:0]         scaled;
  logic signed [spb_pkg::MagW-1:0] avg_val;
  logic signed [spb_pkg::MagW-1:0] res_val;
  logic [BinW-1:0]                 res_idx;

  // APB access: always ready, write on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= spb_pkg::ModeReset;
      win_len_q <= spb_pkg::WinLenReset;
      recip_q   <= spb_pkg::RecipReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        spb_pkg::RegMode:   mode_q    <= pwdata[spb_pkg::ModeW-1:0];
        spb_pkg::RegWinLen: win_len_q <= pwdata[spb_pkg::WinLenW-1:0];
        spb_pkg::RegRecip:  recip_q   <= pwdata[spb_pkg::RecipW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      spb_pkg::RegMode:   prdata = spb_pkg::ApbDataW'(mode_q);
      spb_pkg::RegWinLen: prdata = spb_pkg::ApbDataW'(win_len_q);
      spb_pkg::RegRecip:  prdata = spb_pkg::ApbDataW'(recip_q);
      default:            prdata = '0;
    endcase
  end

  // Clamp window length to 1..WINDOW_MAX
  always_comb begin
    if (win_len_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(win_len_q) > WINDOW_MAX) begin
      n_eff = NW'(WINDOW_MAX);
    end else begin
      n_eff = NW'(win_len_q);
    end
  end

  // Restart index and pointer on a first bin
  assign mag_in  = s_axis_tdata;
  assign idx_in  = s_axis_tuser ? '0 : cnt_q;
  assign wp_base = s_axis_tuser ? '0 : wp_q;

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spb_pkg::ST_IDLE: if (accept) state_d = spb_pkg::ST_SCAN;
      spb_pkg::ST_SCAN: if (left_q == '0) state_d = spb_pkg::ST_MUL;
      spb_pkg::ST_MUL:  state_d = spb_pkg::ST_OUT;
      spb_pkg::ST_OUT:  if (drop || out_free) state_d = spb_pkg::ST_IDLE;
      default:          state_d = spb_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    s_axis_tready = 1'b0;
    rd_issue      = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      spb_pkg::ST_IDLE: s_axis_tready = 1'b1;
      spb_pkg::ST_SCAN: rd_issue = (left_q != '0);
      spb_pkg::ST_MUL:  ;
      spb_pkg::ST_OUT:  out_load = !drop && out_free;
      default:          ;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spb_pkg::ST_IDLE;
      cnt_q       <= '0;
      wp_q        <= '0;
      rptr_q      <= '0;
      left_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= rd_issue;
      if (accept) begin
        cnt_q  <= (idx_in < BinLast) ? idx_in + BinW'(1) : idx_in;
        wp_q   <= (wp_base == PtrLast) ? '0 : wp_base + PtrW'(1);
        rptr_q <= (wp_base == '0) ? PtrLast : wp_base - PtrW'(1);
        // Older bins to read: min(idx + 1, N) - 1
        left_q <= (32'(idx_in) < 32'(n_eff)) ? NW'(idx_in) : n_eff - NW'(1);
      end else if (rd_issue) begin
        rptr_q <= (rptr_q == '0) ? PtrLast : rptr_q - PtrW'(1);
        left_q <= left_q - NW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Window memory: write the new bin, read one older bin per cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_mem[wp_base] <= mag_in;
    end
    rd_data_q <= win_mem[rptr_q];
  end

  // Accumulate sum and peak; newest bin seeds both
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q  <= mag_in;
      idx_q  <= idx_in;
      sum_q  <= SumW'(mag_in);
      peak_q <= (mag_in > spb_pkg::PeakFloor) ? mag_in : spb_pkg::PeakFloor;
    end else if (pend_q) begin
      sum_q <= sum_q + SumW'(rd_data_q);
      if (rd_data_q > peak_q) begin
        peak_q <= rd_data_q;
      end
    end
    if (state_q == spb_pkg::ST_MUL) begin
      prod_q <= ProdW'(sum_q) * ProdW'(signed'({1'b0, recip_q}));
    end
    if (out_load) begin
      out_data_q <= OutW'({res_val, res_idx});
    end
  end

  // Round to nearest, floor shift, saturate to 16 bits
  assign rounded = prod_q + RoundHalf;
  assign scaled  = rounded >>> 16;

  always_comb begin
    if (scaled > SatHi) begin
      avg_val = 16'sh7FFF;
    end else if (scaled < SatLo) begin
      avg_val = -16'sh8000;
    end else begin
      avg_val = spb_pkg::MagW'(scaled);
    end
  end

  // Select result by mode; average drops the first N bins
  always_comb begin
    drop = 1'b0;
    unique case (mode_q)
      spb_pkg::ModeAvg: begin
        drop    = (32'(idx_q) < 32'(n_eff));
        res_idx = idx_q - BinW'(n_eff >> 1);
        res_val = avg_val;
      end
      spb_pkg::ModePeak: begin
        res_idx = idx_q;
        res_val = peak_q;
      end
      default: begin
        res_idx = idx_q;
        res_val = mag_q;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  // An accepted word always starts a memory scan
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == spb_pkg::ST_SCAN))
    else $error("accepted word did not enter scan");

  // Never overwrite a result the receiver has not taken
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("output register overwritten while stalled");

  // All reads are folded in before the multiply
  a_scan_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spb_pkg::ST_MUL) |-> (left_q == '0 && !pend_q))
    else $error("multiply started with reads outstanding");

  // Scan never reads more than the window minus the new bin
  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spb_pkg::ST_SCAN) |-> (32'(left_q) < WINDOW_MAX))
    else $error("scan length exceeds window");
`endif

endmodule

@@ bench/tb_spectrum_bin_smoother.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for spectrum_bin_smoother: stream in, stream out, APB setup.
// A bin-level predictor forms the expected words; depends on spb_pkg and the RTL only.
module tb_spectrum_bin_smoother;

  localparam int unsigned WinMax       = 16;
  localparam int unsigned BinMax       = 4096;
  localparam int unsigned BinW         = $clog2(BinMax);
  localparam int unsigned OutW         = ((BinW + 16 + 7) / 8) * 8;
  localparam int          PeakFloorVal = -19200;
  localparam int          SettleCycles = 24;
  localparam logic [spb_pkg::ModeW-1:0] ModeUnused = 2'd3;

  typedef struct packed {
    logic [BinW-1:0]          idx;
    logic [spb_pkg::MagW-1:0] val;
  } bin_word_t;

  typedef struct {
    bit                       is_cfg;
    logic [1:0]               reg_sel;
    logic [31:0]              reg_val;
    logic [spb_pkg::MagW-1:0] mag;
    logic                     first;
    bit                       typed;
    bin_word_t                fixed;
  } stim_row_t;

  logic                         clk_i;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [spb_pkg::MagW-1:0]     s_axis_tdata  = '0;
  logic                         s_axis_tuser  = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [OutW-1:0]              m_axis_tdata;
  logic                         psel          = 1'b0;
  logic                         penable       = 1'b0;
  logic                         pwrite        = 1'b0;
  logic [spb_pkg::ApbAddrW-1:0] paddr         = '0;
  logic [spb_pkg::ApbDataW-1:0] pwdata        = '0;
  logic [spb_pkg::ApbDataW-1:0] prdata;
  logic                         pready;

  // Predictor state and its copy of the registers
  logic [spb_pkg::ModeW-1:0]       cur_mode  = spb_pkg::ModeReset;
  int                              cur_win   = int'(spb_pkg::WinLenReset);
  int                              cur_recip = int'(spb_pkg::RecipReset);
  logic signed [spb_pkg::MagW-1:0] hist [WinMax];
  int                              bin_pos   = 0;
  int                              wr_slot   = 0;

  bin_word_t   smoothed_q [$];
  stim_row_t   stim_rows [$];
  int          mismatches  = 0;
  int          burst_left  = 0;
  bit          gaps_on     = 1'b1;
  bit          hold_wanted = 1'b0;

  spectrum_bin_smoother #(
    .WINDOW_MAX(WinMax),
    .BIN_MAX   (BinMax)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Append to the stimulus table and to the expected words
  function automatic void add_row(input stim_row_t row);
    stim_rows = {stim_rows, row};
  endfunction

  function automatic void expect_word(input bin_word_t word);
    smoothed_q = {smoothed_q, word};
  endfunction

  // Scale a window sum by 1/N in Q1.16, round half up, clamp to 16 bits
  function automatic logic [spb_pkg::MagW-1:0] scale_by_recip(input int sum, input int recip);
    longint prod;
    longint q;
    prod = longint'(sum) * longint'(recip) + 64'sd32768;
    q = prod >>> 16;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[spb_pkg::MagW-1:0];
  endfunction

  // Store one bin, advance the window and work out the word it yields
  function automatic void smooth_bin(input logic [spb_pkg::MagW-1:0] mag, input logic first,
                                     output bit has_word, output bin_word_t word);
    int idx;
    int n;
    int cnt;
    int slot;
    int sum;
    int peak;
    sum = 0;
    peak = PeakFloorVal;
    if (first) begin
      bin_pos = 0;
      wr_slot = 0;
    end
    idx = bin_pos;
    hist[wr_slot] = mag;
    wr_slot = (wr_slot + 1) % WinMax;
    if (bin_pos < BinMax - 1) bin_pos++;
    n = (cur_win < 1) ? 1 : (cur_win > WinMax) ? WinMax : cur_win;
    cnt = (idx + 1 < n) ? idx + 1 : n;
    for (int k = 1; k <= cnt; k++) begin
      slot = (wr_slot + WinMax - k) % WinMax;
      sum += hist[slot];
      if (hist[slot] > peak) peak = hist[slot];
    end
    has_word = 1'b1;
    case (cur_mode)
      spb_pkg::ModeAvg: begin
        has_word = (idx >= n);
        word.idx = BinW'(idx - n / 2);
        word.val = scale_by_recip(sum, cur_recip);
      end
      spb_pkg::ModePeak: begin
        word.idx = BinW'(idx);
        word.val = peak[spb_pkg::MagW-1:0];
      end
      default: begin
        word.idx = BinW'(idx);
        word.val = mag;
      end
    endcase
  endfunction

  function automatic void row_bin(input logic [spb_pkg::MagW-1:0] mag, input logic first,
                                  input bit typed, input int idx, input int val);
    stim_row_t row;
    row.is_cfg    = 1'b0;
    row.reg_sel   = '0;
    row.reg_val   = '0;
    row.mag       = mag;
    row.first     = first;
    row.typed     = typed;
    row.fixed.idx = BinW'(idx);
    row.fixed.val = spb_pkg::MagW'(val);
    add_row(row);
  endfunction

  function automatic void row_cfg(input logic [1:0] reg_sel, input int value);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_sel = reg_sel;
    row.reg_val = value;
    add_row(row);
  endfunction

  function automatic logic [spb_pkg::MagW-1:0] pick_mag();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return spb_pkg::MagW'($urandom_range(0, 400) - 200);
      3: return spb_pkg::MagW'(PeakFloorVal + $urandom_range(0, 600) - 300);
      default: return spb_pkg::MagW'($urandom);
    endcase
  endfunction

  // Two-phase APB write; the register takes the value at the access edge
  task automatic reg_write(input logic [1:0] reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_sel)
      spb_pkg::RegMode:   cur_mode  = value[spb_pkg::ModeW-1:0];
      spb_pkg::RegWinLen: cur_win   = int'(value[spb_pkg::WinLenW-1:0]);
      spb_pkg::RegRecip:  cur_recip = int'(value[spb_pkg::RecipW-1:0]);
      default: ;
    endcase
    // Hold the bus idle between transfers
    @(posedge clk_i);
  endtask

  // Drop valid, wait for every pending word, then let a silent bin finish
  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Offer one bin in bursts with random gaps; predict once it is taken
  task automatic send_bin(input logic [spb_pkg::MagW-1:0] mag, input logic first,
                          output bit has_word, output bin_word_t word);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= mag;
    s_axis_tuser  <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    smooth_bin(mag, first, has_word, word);
  endtask

  task automatic send_predicted(input logic [spb_pkg::MagW-1:0] mag, input logic first);
    bit has_word;
    bin_word_t word;
    send_bin(mag, first, has_word, word);
    if (has_word) expect_word(word);
  endtask

  // Receiver: check each word taken, stall on its own pattern
  initial begin : rx_side
    bin_word_t want;
    logic [BinW-1:0] got_idx;
    logic [spb_pkg::MagW-1:0] got_val;
    int cyc;
    int style;
    int hold_left;
    cyc = 0;
    style = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got_idx = m_axis_tdata[BinW-1:0];
        got_val = m_axis_tdata[BinW+spb_pkg::MagW-1:BinW];
        if (smoothed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word bin %0d value %0d", $realtime, got_idx,
                     $signed(got_val));
        end else begin
          want = smoothed_q.pop_front();
          if (got_idx !== want.idx || got_val !== want.val) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch bin %0d value %0d, expected bin %0d value %0d",
                       $realtime, got_idx, $signed(got_val), want.idx, $signed(want.val));
          end
        end
      end
      cyc++;
      if (cyc % 157 == 0) style = $urandom_range(0, 4);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= (cyc % 4) != 0;
          3: m_axis_tready <= (cyc % 37) < 22;
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : limit_guard
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stim
    stim_row_t row;
    bit has_word;
    bin_word_t word;
    int n_sel;
    int recip;
    logic [spb_pkg::ModeW-1:0] mode;
    logic first;

    // Directed rows: extremes and corner cases, typed where obvious
    row_bin(16'h7fff, 1'b1, 1'b1, 0, 32767);
    row_bin(16'h8000, 1'b0, 1'b1, 1, -32768);
    row_bin(16'h5555, 1'b0, 1'b1, 2, 16'h5555);
    row_bin(16'haaaa, 1'b1, 1'b1, 0, 16'haaaa);        // restart on a new channel
    row_cfg(spb_pkg::RegMode, int'(spb_pkg::ModePeak));
    row_cfg(spb_pkg::RegWinLen, 4);
    row_bin(spb_pkg::MagW'(-20000), 1'b1, 1'b1, 0, PeakFloorVal); // held at the peak floor
    row_bin(16'h8000, 1'b0, 1'b1, 1, PeakFloorVal);
    row_bin(spb_pkg::MagW'(100), 1'b0, 1'b0, 0, 0);
    row_bin(spb_pkg::MagW'(-5), 1'b0, 1'b0, 0, 0);
    row_bin(spb_pkg::MagW'(-6), 1'b0, 1'b0, 0, 0);
    row_bin(spb_pkg::MagW'(-7), 1'b0, 1'b0, 0, 0);
    row_bin(spb_pkg::MagW'(-8), 1'b0, 1'b0, 0, 0);
    row_cfg(spb_pkg::RegMode, int'(spb_pkg::ModeAvg));
    row_cfg(spb_pkg::RegWinLen, 1);
    row_cfg(spb_pkg::RegRecip, 32768);
    row_bin(spb_pkg::MagW'(5), 1'b1, 1'b0, 0, 0);     // start-up bin, no word
    row_bin(16'hffff, 1'b0, 1'b1, 1, 0);              // half rounds toward plus infinity
    row_bin(spb_pkg::MagW'(1), 1'b0, 1'b1, 2, 1);
    row_cfg(spb_pkg::RegWinLen, 4);
    row_cfg(spb_pkg::RegRecip, 32'h1ffff);
    row_bin(16'h7fff, 1'b1, 1'b0, 0, 0);
    for (int i = 0; i < 4; i++) row_bin(16'h7fff, 1'b0, 1'b0, 0, 0);
    row_cfg(spb_pkg::RegWinLen, 0);                   // zero length acts as one
    row_bin(16'h8000, 1'b0, 1'b0, 0, 0);
    row_cfg(spb_pkg::RegWinLen, 31);                  // oversize length clamps
    row_bin(spb_pkg::MagW'(7), 1'b0, 1'b0, 0, 0);
    row_cfg(spb_pkg::RegMode, int'(ModeUnused));      // spare mode passes through
    row_bin(spb_pkg::MagW'(-123), 1'b0, 1'b1, 7, -123);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.is_cfg) begin
        wait_until_idle();
        reg_write(row.reg_sel, row.reg_val);
      end else begin
        send_bin(row.mag, row.first, has_word, word);
        if (row.typed) expect_word(row.fixed);
        else if (has_word) expect_word(word);
      end
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin mode = spb_pkg::ModeAvg;  n_sel = 16; recip = 4096;  end
        1: begin mode = spb_pkg::ModePeak; n_sel = 16; recip = $urandom_range(0, 131071); end
        2: begin mode = spb_pkg::ModeAvg;  n_sel = 1;  recip = 65536; end
        3: begin mode = spb_pkg::ModeNone; n_sel = 7;  recip = 9362;  end
        4: begin mode = spb_pkg::ModeAvg;  n_sel = 8;  recip = 0;     end
        default: begin
          mode  = spb_pkg::ModeW'($urandom_range(0, 3));
          n_sel = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
          recip = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 131071)
                                              : 65536 / ((n_sel < 1) ? 1 : n_sel);
        end
      endcase
      wait_until_idle();
      reg_write(spb_pkg::RegMode, 32'(mode));
      reg_write(spb_pkg::RegWinLen, n_sel);
      reg_write(spb_pkg::RegRecip, recip);
      gaps_on = (p % 3) != 1;
      if (p == 3) hold_wanted = 1'b1;
      for (int i = 0; i < 85; i++) begin
        first = (i == 0) || ($urandom_range(0, 39) == 0);
        send_predicted(pick_mag(), first);
      end
    end

    // One short channel under a three-bin average
    wait_until_idle();
    reg_write(spb_pkg::RegMode, 32'(spb_pkg::ModeAvg));
    reg_write(spb_pkg::RegWinLen, 3);
    reg_write(spb_pkg::RegRecip, 21845);
    gaps_on = 1'b1;
    for (int i = 0; i < 20; i++) send_predicted(pick_mag(), i == 0);

    wait_until_idle();
    if (smoothed_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/spb_pkg.sv
rtl/core/spectrum_bin_smoother.sv
bench/tb_spectrum_bin_smoother.sv
